FILE: rtl/core/hpsd_pkg.sv
// Shared types and constants for the horizontal port scan detector.
package hpsd_pkg;

    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int KEY_W       = ADDR_W + PORT_W;
    localparam int THR_W       = 5;
    localparam int COUNT_OUT_W = 6;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 8;

    localparam logic [THR_W-1:0] THR_RESET = 5'd16;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_EPOCH  = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SET,
        ST_DONE
    } t_state;

    // Write strobes toward the table storage
    typedef struct packed {
        logic key_we;
        logic cnt_we;
        logic dst_we;
    } t_store_ctl;

endpackage

FILE: rtl/core/hpsd_store.sv
// Key, count and destination memories of the scan detector table.
module hpsd_store #(
    parameter int KW = 6,
    parameter int CW = 6,
    parameter int DW = 11
) (
    input  logic                      i_clk,
    input  hpsd_pkg::t_store_ctl      i_ctl,
    input  logic [KW-1:0]             i_key_waddr,
    input  logic [hpsd_pkg::KEY_W-1:0] i_key_wdata,
    input  logic [CW-1:0]             i_cnt_wdata,
    input  logic [KW-1:0]             i_key_raddr,
    output logic [hpsd_pkg::KEY_W-1:0] o_key_q,
    output logic [CW-1:0]             o_cnt_q,
    input  logic [DW-1:0]             i_dst_waddr,
    input  logic [hpsd_pkg::ADDR_W-1:0] i_dst_wdata,
    input  logic [DW-1:0]             i_dst_raddr,
    output logic [hpsd_pkg::ADDR_W-1:0] o_dst_q
);
    import hpsd_pkg::*;

    localparam int KEY_DEPTH = 1 << KW;
    localparam int DST_DEPTH = 1 << DW;

    logic [KEY_W-1:0]  r_key_mem [KEY_DEPTH];
    logic [CW-1:0]     r_cnt_mem [KEY_DEPTH];
    logic [ADDR_W-1:0] r_dst_mem [DST_DEPTH];

    // Key and count table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            r_key_mem[i_key_waddr] <= i_key_wdata;
        end
        if (i_ctl.cnt_we) begin
            r_cnt_mem[i_key_waddr] <= i_cnt_wdata;
        end
        o_key_q <= r_key_mem[i_key_raddr];
        o_cnt_q <= r_cnt_mem[i_key_raddr];
    end

    // Destination sets, one row of set slots per key entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.dst_we) begin
            r_dst_mem[i_dst_waddr] <= i_dst_wdata;
        end
        o_dst_q <= r_dst_mem[i_dst_raddr];
    end

endmodule

FILE: rtl/core/horizontal_port_scan_detector_top.sv
// Top level of the horizontal port scan detector with its sequencer.
//
// One item is taken at a time. A packet item walks the key table one entry
// per cycle through a single shared equality comparator (stopping at the
// first matching key), and on a hit walks that key's destination set one
// slot per cycle (up to the stored count, at most SET_DEPTH slots). An epoch
// item goes straight to the result. The result is held in an output register
// until taken, and the next item is accepted in the cycle after it leaves.
// An epoch item clears all valid and reported marks at once; no clearing
// pass is needed after reset.
module horizontal_port_scan_detector_top #(
    parameter int KEY_ENTRIES = 64,
    parameter int SET_DEPTH   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: scan_threshold
    input  logic                              i_cfg_wr_en,
    input  logic [hpsd_pkg::THR_W-1:0]        i_cfg_wr_data,
    // input items
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] source_addr, [47:32] target_port, [79:48] target_addr
    input  logic [hpsd_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [0] op
    input  logic                              i_s_axis_tuser,
    // result items
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] alarm, [6:1] distinct_count, [7] table_full
    output logic [hpsd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import hpsd_pkg::*;

    localparam int KW    = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
    localparam int SW    = $clog2(SET_DEPTH);
    localparam int CW    = $clog2(SET_DEPTH + 1);
    localparam int DW    = KW + SW;
    localparam int CMP_W = (CW > THR_W) ? CW + 1 : THR_W + 1;

    localparam logic [KW-1:0] LAST_KEY  = KW'(KEY_ENTRIES - 1);
    localparam logic [CW-1:0] SET_FULL  = CW'(SET_DEPTH);
    localparam logic [CW-1:0] ONE_COUNT = CW'(1);

    // control registers
    t_state                 r_state, n_state;
    logic [THR_W-1:0]       r_thr;
    logic [KEY_ENTRIES-1:0] r_valid, n_valid;
    logic [KEY_ENTRIES-1:0] r_reported, n_reported;
    logic                   r_have_free, n_have_free;

    // item and walk registers
    logic [ADDR_W-1:0]      r_src, n_src;
    logic [PORT_W-1:0]      r_port, n_port;
    logic [ADDR_W-1:0]      r_dst, n_dst;
    logic [KW-1:0]          r_k, n_k;
    logic [KW-1:0]          r_free, n_free;
    logic [KW-1:0]          r_hit, n_hit;
    logic [SW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_n, n_n;
    logic [OUT_DATA_W-1:0]  r_out, n_out;

    // storage interface
    t_store_ctl             st_ctl;
    logic [KW-1:0]          key_waddr, key_raddr;
    logic [KEY_W-1:0]       key_q;
    logic [CW-1:0]          cnt_wdata, cnt_q;
    logic [DW-1:0]          dst_waddr, dst_raddr;
    logic [ADDR_W-1:0]      dst_q;

    // shared comparator
    logic [KEY_W-1:0]       cmp_a, cmp_b;
    logic                   cmp_eq;

    logic                   in_acc;
    logic                   key_hit, key_last, free_now;
    logic [KW-1:0]          slot_free;
    logic                   set_last, set_done;
    logic [CW-1:0]          n_after;
    logic                   alarm_now;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    hpsd_store #(
        .KW (KW),
        .CW (CW),
        .DW (DW)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (st_ctl),
        .i_key_waddr (key_waddr),
        .i_key_wdata ({r_src, r_port}),
        .i_cnt_wdata (cnt_wdata),
        .i_key_raddr (key_raddr),
        .o_key_q     (key_q),
        .o_cnt_q     (cnt_q),
        .i_dst_waddr (dst_waddr),
        .i_dst_wdata (r_dst),
        .i_dst_raddr (dst_raddr),
        .o_dst_q     (dst_q)
    );

    // Shared equality unit: key compare while scanning, destination in the set
    always_comb begin
        if (r_state == ST_SET) begin
            cmp_a = {{PORT_W{1'b0}}, r_dst};
            cmp_b = {{PORT_W{1'b0}}, dst_q};
        end else begin
            cmp_a = {r_src, r_port};
            cmp_b = key_q;
        end
        cmp_eq = (cmp_a == cmp_b);
    end

    // Walk status
    always_comb begin
        key_hit   = r_valid[r_k] && cmp_eq;
        key_last  = (r_k == LAST_KEY);
        free_now  = !r_valid[r_k];
        slot_free = r_have_free ? r_free : r_k;
        set_last  = ((CW'(r_j) + ONE_COUNT) == r_n);
        set_done  = cmp_eq || set_last;
        n_after   = (!cmp_eq && (r_n < SET_FULL)) ? r_n + ONE_COUNT : r_n;
        alarm_now = (CMP_W'(n_after) > CMP_W'(r_thr)) && !r_reported[r_hit];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_axis_tuser == OP_EPOCH) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (key_hit) begin
                    n_state = ST_SET;
                end else if (key_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SET: begin
                if (set_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and storage control
    always_comb begin
        n_valid     = r_valid;
        n_reported  = r_reported;
        n_have_free = r_have_free;
        n_src       = r_src;
        n_port      = r_port;
        n_dst       = r_dst;
        n_k         = r_k;
        n_free      = r_free;
        n_hit       = r_hit;
        n_j         = r_j;
        n_n         = r_n;
        n_out       = r_out;
        st_ctl      = '0;
        key_waddr   = slot_free;
        cnt_wdata   = ONE_COUNT;
        key_raddr   = '0;
        dst_waddr   = {slot_free, {SW{1'b0}}};
        dst_raddr   = {r_k, {SW{1'b0}}};
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                n_src       = i_s_axis_tdata[31:0];
                n_port      = i_s_axis_tdata[47:32];
                n_dst       = i_s_axis_tdata[79:48];
                n_k         = '0;
                n_have_free = 1'b0;
                n_out       = '0;
                if (in_acc && i_s_axis_tuser == OP_EPOCH) begin
                    n_valid    = '0;
                    n_reported = '0;
                end
            end
            ST_SCAN: begin
                key_raddr = r_k + KW'(1);
                n_k       = r_k + KW'(1);
                if (free_now && !r_have_free) begin
                    n_have_free = 1'b1;
                    n_free      = r_k;
                end
                if (key_hit) begin
                    n_hit = r_k;
                    n_n   = cnt_q;
                    n_j   = '0;
                end else if (key_last) begin
                    if (r_have_free || free_now) begin
                        // new key takes the lowest free entry
                        st_ctl.key_we          = 1'b1;
                        st_ctl.cnt_we          = 1'b1;
                        st_ctl.dst_we          = 1'b1;
                        n_valid[slot_free]     = 1'b1;
                        n_reported[slot_free]  = 1'b0;
                        n_out = {1'b0, COUNT_OUT_W'(ONE_COUNT), 1'b0};
                    end else begin
                        n_out = {1'b1, {COUNT_OUT_W{1'b0}}, 1'b0};
                    end
                end
            end
            ST_SET: begin
                dst_raddr = {r_hit, r_j + SW'(1)};
                n_j       = r_j + SW'(1);
                key_waddr = r_hit;
                dst_waddr = {r_hit, r_n[SW-1:0]};
                cnt_wdata = n_after;
                if (set_done) begin
                    st_ctl.cnt_we = 1'b1;
                    st_ctl.dst_we = !cmp_eq && (r_n < SET_FULL);
                    if (alarm_now) begin
                        n_reported[r_hit] = 1'b1;
                    end
                    n_out = {1'b0, COUNT_OUT_W'(n_after), alarm_now};
                end
            end
            ST_DONE: begin
                o_m_axis_tvalid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_m_axis_tdata = r_out;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= THR_RESET;
            r_valid     <= '0;
            r_reported  <= '0;
            r_have_free <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_reported  <= n_reported;
            r_have_free <= n_have_free;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_port <= n_port;
        r_dst  <= n_dst;
        r_k    <= n_k;
        r_free <= n_free;
        r_hit  <= n_hit;
        r_j    <= n_j;
        r_n    <= n_n;
        r_out  <= n_out;
    end

endmodule

FILE: rtl/core/hpsd_checker.sv
// Port-level checks for the scan detector, bound to the top level.
module hpsd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [hpsd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import hpsd_pkg::*;

    // one item in flight: never ready while a result is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while result pending");

    // an accepted item closes the input side for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still ready after accept");

    // exactly one result per item
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> !o_m_axis_tvalid)
        else $error("second result without new item");

    // a dropped packet reports no alarm and no count
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[7]) |-> (o_m_axis_tdata[6:0] == 7'd0))
        else $error("table full with alarm or count");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind horizontal_port_scan_detector_top hpsd_checker u_hpsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: bench/scan_alarm_checker.sv
// Scoreboard for the port scan detector: tracks the key table and checks every result item.
module scan_alarm_checker #(
    parameter int KEY_ENTRIES = 64,
    parameter int SET_DEPTH   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [hpsd_pkg::THR_W-1:0]         i_cfg_wr_data,
    input  logic                               i_s_axis_tvalid,
    input  logic                               i_s_axis_tready,
    // [31:0] source_addr, [47:32] target_port, [79:48] target_addr
    input  logic [hpsd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] op
    input  logic                               i_s_axis_tuser,
    input  logic                               i_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] alarm, [6:1] distinct_count, [7] table_full
    input  logic [hpsd_pkg::OUT_DATA_W-1:0]    i_m_axis_tdata,
    output int                                 o_failures,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hpsd_pkg::*;

    // Result item, lowest bit last
    typedef struct packed {
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] distinct_count;
        logic                   alarm;
    } t_scan_verdict;

    // Shadow copy of the key table and destination sets
    logic [THR_W-1:0]  scan_threshold;
    bit                key_valid    [KEY_ENTRIES];
    bit                key_reported [KEY_ENTRIES];
    logic [ADDR_W-1:0] key_source   [KEY_ENTRIES];
    logic [PORT_W-1:0] key_port     [KEY_ENTRIES];
    int                key_count    [KEY_ENTRIES];
    logic [ADDR_W-1:0] seen_dst     [KEY_ENTRIES][SET_DEPTH];

    t_scan_verdict expected_verdicts[$];
    int            failures     = 0;
    int            result_index = 0;
    int            pending_count = 0;

    assign o_failures = failures;
    assign o_pending  = pending_count;

    function automatic void clear_keys();
        foreach (key_valid[k]) begin
            key_valid[k]    = 1'b0;
            key_reported[k] = 1'b0;
        end
    endfunction

    // Apply one item to the shadow table and return the result it should produce
    function automatic t_scan_verdict predict_scan_verdict(logic op, logic [ADDR_W-1:0] src,
                                                           logic [PORT_W-1:0] port,
                                                           logic [ADDR_W-1:0] dst);
        t_scan_verdict v;
        int            hit;
        int            free_slot;
        int            n;
        bit            seen;
        v         = '0;
        hit       = -1;
        free_slot = -1;
        seen      = 1'b0;
        if (op == OP_EPOCH) begin
            clear_keys();
            return v;
        end
        // first matching key, lowest free entry
        for (int k = 0; k < KEY_ENTRIES; k++) begin
            if (key_valid[k]) begin
                if (hit < 0 && key_source[k] == src && key_port[k] == port)
                    hit = k;
            end else if (free_slot < 0) begin
                free_slot = k;
            end
        end
        if (hit < 0) begin
            if (free_slot < 0) begin
                v.table_full = 1'b1;
            end else begin
                key_valid[free_slot]    = 1'b1;
                key_reported[free_slot] = 1'b0;
                key_source[free_slot]   = src;
                key_port[free_slot]     = port;
                key_count[free_slot]    = 1;
                seen_dst[free_slot][0]  = dst;
                v.distinct_count        = COUNT_OUT_W'(1);
            end
            return v;
        end
        // known key: add destination if unseen, count saturates at set depth
        n = key_count[hit];
        for (int j = 0; j < n; j++)
            if (seen_dst[hit][j] == dst)
                seen = 1'b1;
        if (!seen && n < SET_DEPTH) begin
            seen_dst[hit][n] = dst;
            n++;
        end
        key_count[hit]   = n;
        v.distinct_count = COUNT_OUT_W'(n);
        if (n > scan_threshold && !key_reported[hit]) begin
            key_reported[hit] = 1'b1;
            v.alarm           = 1'b1;
        end
        return v;
    endfunction

    task automatic note_mismatch(string field, int want, int got);
        failures++;
        if (failures <= 10)
            $display("result %0d: %0s expected %0d, got %0d", result_index, field, want, got);
    endtask

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_scan_verdict want;
        t_scan_verdict got;
        t_scan_verdict pred;
        if (!i_rst_n) begin
            scan_threshold = THR_RESET;
            clear_keys();
            expected_verdicts.delete();
        end else begin
            if (i_cfg_wr_en)
                scan_threshold = i_cfg_wr_data;
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pred = predict_scan_verdict(
                    i_s_axis_tuser,
                    i_s_axis_tdata[ADDR_W-1:0],
                    i_s_axis_tdata[ADDR_W +: PORT_W],
                    i_s_axis_tdata[KEY_W +: ADDR_W]);
                expected_verdicts = {expected_verdicts, pred};
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_scan_verdict'(i_m_axis_tdata);
                if (expected_verdicts.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d: unexpected item 0x%02h", result_index,
                                 i_m_axis_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.alarm !== want.alarm)
                        note_mismatch("alarm", int'(want.alarm), int'(got.alarm));
                    if (got.distinct_count !== want.distinct_count)
                        note_mismatch("distinct_count", int'(want.distinct_count),
                                      int'(got.distinct_count));
                    if (got.table_full !== want.table_full)
                        note_mismatch("table_full", int'(want.table_full),
                                      int'(got.table_full));
                end
                result_index++;
            end
        end
        pending_count = expected_verdicts.size();
    end

endmodule

FILE: bench/tb_horizontal_port_scan_detector_top.sv
// Stimulus and verdict for the horizontal port scan detector.
module tb_horizontal_port_scan_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hpsd_pkg::*;

    localparam int KEY_ENTRIES     = 64;
    localparam int SET_DEPTH       = 32;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int CYCLE_LIMIT     = 2_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [THR_W-1:0]      i_cfg_wr_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    int failure_count;
    int pending_results;
    int items_sent = 0;
    bit no_idle    = 1'b0;

    // Traffic pools so keys and destinations repeat
    logic [ADDR_W-1:0] src_pool  [4];
    logic [PORT_W-1:0] port_pool [2];
    logic [ADDR_W-1:0] dst_pool  [40];

    horizontal_port_scan_detector_top #(
        .KEY_ENTRIES (KEY_ENTRIES),
        .SET_DEPTH   (SET_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    scan_alarm_checker #(
        .KEY_ENTRIES (KEY_ENTRIES),
        .SET_DEPTH   (SET_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_failures      (failure_count),
        .o_pending       (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(logic op, logic [ADDR_W-1:0] src, logic [PORT_W-1:0] port,
                             logic [ADDR_W-1:0] dst);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) begin
                i_s_axis_tdata = IN_DATA_W'({$urandom, $urandom, $urandom});
                i_s_axis_tuser = 1'($urandom);
                @(negedge i_clk);
            end
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {dst, port, src};
        i_s_axis_tuser  = op;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Threshold changes only with the block drained
    task automatic write_threshold(logic [THR_W-1:0] value);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // Result side back-pressure
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    initial begin
        logic [THR_W-1:0]  phase_thr [NUM_PHASES];
        logic [ADDR_W-1:0] src;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] dst;
        int                start;
        int                r;

        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_PACKET;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: epoch on empty table, field extremes, seen and unseen destinations
        send_item(OP_EPOCH,  32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PACKET, 32'h0,         16'h0,    32'h0);
        send_item(OP_PACKET, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PACKET, 32'h0,         16'h0,    32'h0);
        send_item(OP_PACKET, 32'h0,         16'h0,    32'hFFFF_FFFF);
        send_item(OP_PACKET, 32'h0,         16'hFFFF, 32'h0);
        send_item(OP_PACKET, 32'hFFFF_FFFF, 16'h0,    32'h0);
        send_item(OP_EPOCH,  32'h0,         16'h0,    32'h0);
        send_item(OP_PACKET, 32'h0,         16'h0,    32'hFFFF_FFFF);

        // Threshold zero: new key never alarms, the next hit does, once
        write_threshold(5'd0);
        send_item(OP_PACKET, 32'hA5A5_A5A5, 16'h5A5A, 32'h1234_5678);
        send_item(OP_PACKET, 32'hA5A5_A5A5, 16'h5A5A, 32'h1234_5678);
        send_item(OP_PACKET, 32'hA5A5_A5A5, 16'h5A5A, 32'h8765_4321);
        send_item(OP_EPOCH,  32'h0,         16'h0,    32'h0);
        send_item(OP_PACKET, 32'hA5A5_A5A5, 16'h5A5A, 32'h8765_4321);
        send_item(OP_PACKET, 32'hA5A5_A5A5, 16'h5A5A, 32'h8765_4321);

        // Threshold one: second destination alarms
        write_threshold(5'd1);
        send_item(OP_PACKET, 32'h5A5A_5A5A, 16'hA5A5, 32'h0000_0001);
        send_item(OP_PACKET, 32'h5A5A_5A5A, 16'hA5A5, 32'h8000_0000);
        send_item(OP_PACKET, 32'h5A5A_5A5A, 16'hA5A5, 32'h0000_0001);

        phase_thr = '{5'd31, 5'd0, 5'($urandom_range(0, 31)), 5'd2,
                      5'($urandom_range(0, 31)), 5'd16, 5'd31};

        // Random phases, each under its own threshold
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_threshold(phase_thr[ph]);
            foreach (src_pool[i])  src_pool[i]  = $urandom;
            foreach (port_pool[i]) port_pool[i] = 16'($urandom);
            foreach (dst_pool[i])  dst_pool[i]  = $urandom;
            start = items_sent;
            while (items_sent - start < ITEMS_PER_PHASE) begin
                no_idle = ($urandom_range(0, 4) == 0);
                r       = $urandom_range(0, 99);
                if (r < 30) begin
                    // pooled traffic: repeated keys and destinations
                    repeat (24)
                        send_item(OP_PACKET, src_pool[$urandom_range(0, 3)],
                                  port_pool[$urandom_range(0, 1)],
                                  dst_pool[$urandom_range(0, 39)]);
                end else if (r < 45) begin
                    // one key sweeps many destinations, up to or past set depth
                    if ($urandom_range(0, 1))
                        send_item(OP_EPOCH, $urandom, 16'($urandom), $urandom);
                    src  = src_pool[$urandom_range(0, 3)];
                    port = port_pool[$urandom_range(0, 1)];
                    repeat ($urandom_range(30, 40)) begin
                        dst = ($urandom_range(0, 4) == 0) ? dst_pool[$urandom_range(0, 39)]
                                                          : $urandom;
                        send_item(OP_PACKET, src, port, dst);
                    end
                end else if (r < 58) begin
                    // many distinct keys until the table overflows
                    repeat (70) begin
                        if ($urandom_range(0, 7) == 0)
                            send_item(OP_PACKET, src_pool[$urandom_range(0, 3)],
                                      port_pool[$urandom_range(0, 1)], $urandom);
                        else
                            send_item(OP_PACKET, $urandom, 16'($urandom), $urandom);
                    end
                end else if (r < 65) begin
                    send_item(OP_EPOCH, $urandom, 16'($urandom), $urandom);
                end else begin
                    // noise, rare epochs
                    repeat (12)
                        send_item(($urandom_range(0, 15) == 0) ? OP_EPOCH : OP_PACKET,
                                  $urandom, 16'($urandom), $urandom);
                end
            end
        end

        // Drain and settle
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_results != 0)
            @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        if (failure_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: horizontal_port_scan_detector_top.f
rtl/core/hpsd_pkg.sv
rtl/core/hpsd_store.sv
rtl/core/horizontal_port_scan_detector_top.sv
rtl/core/hpsd_checker.sv
bench/scan_alarm_checker.sv
bench/tb_horizontal_port_scan_detector_top.sv
